// ----- rtl/pfdw_pkg.sv -----
// ----------------------------------------------------------------------------
// pfdw_pkg
// Types and constants shared by the panel frame diff writer modules.
// ----------------------------------------------------------------------------
package pfdw_pkg;

  // Field widths of the pixel and panel words
  localparam int unsigned REQ_W        = 1;
  localparam int unsigned COL_W        = 6;
  localparam int unsigned ROW_W        = 7;
  localparam int unsigned COLOR_W      = 3;
  localparam int unsigned PANEL_ADDR_W = COL_W + ROW_W;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PIXEL  = 1'b0;
  localparam logic [REQ_W-1:0] REQ_REDRAW = 1'b1;

  // Epoch tags kept next to each shown color; tag zero is never current
  localparam int unsigned        EPOCH_W     = 6;
  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Input word
  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [COL_W-1:0]   pixel_col;
    logic [ROW_W-1:0]   pixel_row;
    logic [COLOR_W-1:0] pixel_color;
  } pfdw_in_t;

  // Output word
  typedef struct packed {
    logic [PANEL_ADDR_W-1:0] panel_addr;
    logic [COLOR_W-1:0]      panel_data;
  } pfdw_out_t;

  // Classified job handed from front to back
  typedef struct packed {
    logic                    redraw;
    logic [PANEL_ADDR_W-1:0] panel_addr;
    logic [COLOR_W-1:0]      color;
  } pfdw_job_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic clearing;
    logic stage_busy;
  } pfdw_back_status_t;

endpackage

// ----- rtl/pfdw_front.sv -----
// ----------------------------------------------------------------------------
// pfdw_front
// Accepts pixel words, drops out-of-range pixels, computes the store index
// and the panel address, and holds the row offset register.
// ----------------------------------------------------------------------------
module pfdw_front import pfdw_pkg::*; #(
  parameter int unsigned VIEW_COLS = 64,
  parameter int unsigned VIEW_ROWS = 128,
  parameter int unsigned IDX_W     = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pfdw_in_t         in_data_i,
  input  logic             cfg_we_i,
  input  logic [ROW_W-1:0] cfg_data_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output logic [IDX_W-1:0] push_idx_o,
  output pfdw_job_t        push_job_o
);

  logic [ROW_W-1:0] row_offset_q;
  logic             is_redraw;
  logic             in_range;
  logic [ROW_W-1:0] panel_x;
  logic [COL_W-1:0] col_inv;

  // Row offset register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_offset_q <= '0;
    end else if (cfg_we_i) begin
      row_offset_q <= cfg_data_i;
    end
  end

  // Classify
  assign is_redraw = (in_data_i.req_type == REQ_REDRAW);
  assign in_range  = (32'(in_data_i.pixel_col) < VIEW_COLS) &&
                     (32'(in_data_i.pixel_row) < VIEW_ROWS);

  // Panel address: mirrored column on the high bits, wrapped row below
  assign panel_x = in_data_i.pixel_row + row_offset_q;
  assign col_inv = COL_W'(VIEW_COLS - 32'd1 - 32'(in_data_i.pixel_col));

  assign push_idx_o = IDX_W'(32'(in_data_i.pixel_row) * VIEW_COLS +
                             32'(in_data_i.pixel_col));
  assign push_job_o = '{redraw:     is_redraw,
                        panel_addr: {col_inv, panel_x},
                        color:      in_data_i.pixel_color};

  // Out-of-range pixels are taken but never queued
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && (is_redraw || in_range);

endmodule

// ----- rtl/pfdw_queue.sv -----
// ----------------------------------------------------------------------------
// pfdw_queue
// Small register FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
module pfdw_queue import pfdw_pkg::*; #(
  parameter int unsigned W = 17
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_valid_i,
  output logic         wr_ready_o,
  input  logic [W-1:0] wr_data_i,
  output logic         rd_valid_o,
  input  logic         rd_pop_i,
  output logic [W-1:0] rd_data_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign wr_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = slot_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_pop_i && rd_valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/pfdw_back.sv -----
// ----------------------------------------------------------------------------
// pfdw_back
// Reads the shown-color store, compares against the new color and the
// current epoch, writes back, and drives the output register. A redraw
// bumps the epoch; when the epoch runs out, a sweep resets all tags.
// ----------------------------------------------------------------------------
module pfdw_back import pfdw_pkg::*; #(
  parameter int unsigned PIX_DEPTH = 8192
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  logic [$clog2(PIX_DEPTH)-1:0]  q_idx_i,
  input  pfdw_job_t                     q_job_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pfdw_out_t                     out_data_o,
  output pfdw_back_status_t             status_o
);

  localparam int unsigned IDX_W = $clog2(PIX_DEPTH);

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [COLOR_W-1:0] color;
  } mem_word_t;

  mem_word_t        mem_q [PIX_DEPTH];
  mem_word_t        rd_q;

  // Stage registers
  logic             b_valid_q;
  logic [IDX_W-1:0] b_idx_q;
  pfdw_job_t        b_job_q;

  // Last write, forwarded to the read issued at the same edge
  logic             fwd_valid_q;
  logic [IDX_W-1:0] fwd_idx_q;
  mem_word_t        fwd_q;

  logic [EPOCH_W-1:0] epoch_q;
  logic               clr_active_q;
  logic [IDX_W-1:0]   clr_cnt_q;
  logic               out_valid_q;
  pfdw_out_t          out_data_q;

  mem_word_t        cur;
  logic             b_emit, b_done, b_load, clr_start, out_free;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  mem_word_t        mem_wdata;

  // Compare against the freshest copy of the entry
  assign cur      = (fwd_valid_q && fwd_idx_q == b_idx_q) ? fwd_q : rd_q;
  assign b_emit   = !b_job_q.redraw &&
                    ((cur.tag != epoch_q) || (cur.color != b_job_q.color));
  assign out_free = !out_valid_q || out_ready_i;
  assign b_done   = b_valid_q && (!b_emit || out_free);

  assign clr_start = b_done && b_job_q.redraw && (epoch_q == EPOCH_LAST);
  assign b_load    = q_valid_i && (!b_valid_q || b_done) && !clr_active_q && !clr_start;
  assign q_pop_o   = b_load;

  // Single write port: tag sweep or pixel update
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = b_idx_q;
    mem_wdata = '{tag: epoch_q, color: b_job_q.color};
    if (clr_active_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '{tag: EPOCH_NONE, color: '0};
    end else if (b_done && b_emit) begin
      mem_we = 1'b1;
    end
  end

  // Shown-color store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (b_load) begin
      rd_q <= mem_q[q_idx_i];
    end
  end

  // Stage and forwarding payload
  always_ff @(posedge clk_i) begin
    if (b_load) begin
      b_idx_q <= q_idx_i;
      b_job_q <= q_job_i;
    end
    if (b_done && b_emit) begin
      fwd_idx_q  <= b_idx_q;
      fwd_q      <= mem_wdata;
      out_data_q <= '{panel_addr: b_job_q.panel_addr, panel_data: b_job_q.color};
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q    <= 1'b0;
      fwd_valid_q  <= 1'b0;
      epoch_q      <= EPOCH_FIRST;
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (b_load) begin
        b_valid_q <= 1'b1;
      end else if (b_done) begin
        b_valid_q <= 1'b0;
      end

      if (clr_start || clr_active_q) begin
        fwd_valid_q <= 1'b0;
      end else if (b_done && b_emit) begin
        fwd_valid_q <= 1'b1;
      end

      // Epoch advance on redraw, tag sweep when it runs out
      if (clr_start) begin
        clr_active_q <= 1'b1;
        clr_cnt_q    <= '0;
      end else if (b_done && b_job_q.redraw) begin
        epoch_q <= epoch_q + 1'b1;
      end else if (clr_active_q) begin
        if (clr_cnt_q == IDX_W'(PIX_DEPTH - 1)) begin
          clr_active_q <= 1'b0;
          epoch_q      <= EPOCH_FIRST;
        end else begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
        end
      end

      // Output register
      if (b_done && b_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign status_o    = '{clearing: clr_active_q, stage_busy: b_valid_q};

endmodule

// ----- rtl/panel_frame_diff_writer_unit.sv -----
// ----------------------------------------------------------------------------
// panel_frame_diff_writer_unit
// Dirty-pixel diff writer for an LED panel.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one word per cycle:
// while the queue has room: a pixel update or a full-redraw request. A pixel
// whose color differs from the one last sent, or whose entry is stale, gives
// one word on the output channel (out_valid_o/out_ready_i/out_data_o) with
// the panel address and color. Redraws and out-of-range pixels give nothing.
// Throughput is one word per cycle while the output is not stalled and no
// sweep runs, set by one read and one write of the shown-color store per
// cycle. A four-entry queue separates the front from the store stage, so
// inputs keep flowing while the receiver stalls until the queue fills; the
// output register then holds its word until taken.
// After reset, and after every 63rd redraw, a tag sweep over all VIEW_COLS *
// VIEW_ROWS entries (8192 by default) runs; the queue still fills, but no
// pixel reaches the store until the sweep is done. The user writes row_offset
// through cfg_we_i/cfg_data_i only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module panel_frame_diff_writer_unit import pfdw_pkg::*; #(
  parameter int unsigned VIEW_COLS = 64,
  parameter int unsigned VIEW_ROWS = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pfdw_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pfdw_out_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic [ROW_W-1:0] cfg_data_i
);

  localparam int unsigned PIX_DEPTH = VIEW_COLS * VIEW_ROWS;
  localparam int unsigned IDX_W     = $clog2(PIX_DEPTH);
  localparam int unsigned Q_W       = IDX_W + $bits(pfdw_job_t);

  logic              push_valid, push_ready;
  logic [IDX_W-1:0]  push_idx;
  pfdw_job_t         push_job;
  logic              q_valid, q_pop;
  logic [Q_W-1:0]    q_data;
  logic [IDX_W-1:0]  q_idx;
  pfdw_job_t         q_job;
  pfdw_back_status_t back_status;

  // Front: classify and address
  pfdw_front #(
    .VIEW_COLS (VIEW_COLS),
    .VIEW_ROWS (VIEW_ROWS),
    .IDX_W     (IDX_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_idx_o   (push_idx),
    .push_job_o   (push_job)
  );

  // Queue between front and back
  pfdw_queue #(
    .W (Q_W)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  ({push_idx, push_job}),
    .rd_valid_o (q_valid),
    .rd_pop_i   (q_pop),
    .rd_data_o  (q_data)
  );

  assign q_idx = q_data[Q_W-1 -: IDX_W];
  assign q_job = pfdw_job_t'(q_data[$bits(pfdw_job_t)-1:0]);

  // Back: store, compare, output
  pfdw_back #(
    .PIX_DEPTH (PIX_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_idx_i     (q_idx),
    .q_job_i     (q_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .status_o    (back_status)
  );

  // No item sits in the store stage during a tag sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.clearing |-> !back_status.stage_busy)
    else $error("store stage busy during tag sweep");

  // The sweep blocks the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.clearing |-> !q_pop)
    else $error("queue popped during tag sweep");

  // Pops only from a non-empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // A new output word appears only after the store stage held an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(back_status.stage_busy))
    else $error("output word without a stage item");

endmodule

// ----- dv/panel_frame_diff_writer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// panel_frame_diff_writer_unit_tb
// Self-checking bench for the panel frame diff writer. A short table of
// pixel and redraw words runs first, then randomized phases, each under its
// own row_offset. Most pixels land in a few hot spots so that unchanged,
// changed and stale pixels all occur. A scoreboard keeps its own copy of the
// shown colors and stale flags, and checks every panel write in order.
// ----------------------------------------------------------------------------
module panel_frame_diff_writer_unit_tb;
  import pfdw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VIEW_COLS      = 64;
  localparam int unsigned VIEW_ROWS      = 128;
  localparam int unsigned PIX_COUNT      = VIEW_COLS * VIEW_ROWS;
  localparam int unsigned PANEL_LINE     = 128;
  // a tag sweep over all PIX_COUNT entries stalls the input; allow several
  localparam int unsigned WATCHDOG_LIMIT = 5 * PIX_COUNT;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned MAX_REPORTS    = 10;

  // How a table row is checked
  typedef enum logic [1:0] {
    CHK_BY_MODEL,
    CHK_NO_WORD,
    CHK_TYPED
  } chk_e;

  typedef struct packed {
    logic [REQ_W-1:0]        req;
    logic [COL_W-1:0]        col;
    logic [ROW_W-1:0]        row;
    logic [COLOR_W-1:0]      color;
    chk_e                    chk;
    logic [PANEL_ADDR_W-1:0] addr;
    logic [COLOR_W-1:0]      data;
  } dir_row_t;

  typedef struct packed {
    logic [ROW_W-1:0] offset;
    int unsigned      count;
    int unsigned      redraw_pct;
    int unsigned      idle_pct;
  } phase_t;

  // Directed words, run with row_offset still at its reset value of 0
  localparam int unsigned DIR_N = 18;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{REQ_PIXEL,  6'd0,  7'd0,   3'd5, CHK_TYPED,    13'd8064, 3'd5},
    '{REQ_PIXEL,  6'd63, 7'd127, 3'd7, CHK_TYPED,    13'd127,  3'd7},
    '{REQ_PIXEL,  6'd63, 7'd127, 3'd7, CHK_NO_WORD,  13'd0,    3'd0},
    '{REQ_PIXEL,  6'd63, 7'd127, 3'd0, CHK_TYPED,    13'd127,  3'd0},
    '{REQ_PIXEL,  6'd0,  7'd127, 3'd0, CHK_TYPED,    13'd8191, 3'd0},
    '{REQ_PIXEL,  6'd63, 7'd0,   3'd2, CHK_TYPED,    13'd0,    3'd2},
    '{REQ_PIXEL,  6'd42, 7'd85,  3'd1, CHK_BY_MODEL, 13'd0,    3'd0},
    '{REQ_PIXEL,  6'd21, 7'd42,  3'd4, CHK_BY_MODEL, 13'd0,    3'd0},
    '{REQ_REDRAW, 6'd63, 7'd127, 3'd7, CHK_NO_WORD,  13'd0,    3'd0},
    '{REQ_PIXEL,  6'd63, 7'd127, 3'd0, CHK_TYPED,    13'd127,  3'd0},
    '{REQ_PIXEL,  6'd0,  7'd0,   3'd5, CHK_TYPED,    13'd8064, 3'd5},
    '{REQ_PIXEL,  6'd0,  7'd0,   3'd5, CHK_NO_WORD,  13'd0,    3'd0},
    '{REQ_PIXEL,  6'd0,  7'd0,   3'd3, CHK_BY_MODEL, 13'd0,    3'd0},
    '{REQ_REDRAW, 6'd0,  7'd0,   3'd0, CHK_NO_WORD,  13'd0,    3'd0},
    '{REQ_PIXEL,  6'd63, 7'd0,   3'd2, CHK_TYPED,    13'd0,    3'd2},
    '{REQ_PIXEL,  6'd31, 7'd64,  3'd6, CHK_BY_MODEL, 13'd0,    3'd0},
    '{REQ_PIXEL,  6'd32, 7'd63,  3'd1, CHK_BY_MODEL, 13'd0,    3'd0},
    '{REQ_PIXEL,  6'd32, 7'd63,  3'd1, CHK_NO_WORD,  13'd0,    3'd0}
  };

  // Random phases; the redraw-heavy one crosses the epoch wrap, the last is calm
  localparam int unsigned PHASE_N = 6;
  localparam phase_t PHASES [PHASE_N] = '{
    '{7'd127, 400, 1,  25},
    '{7'd1,   300, 2,  10},
    '{7'd64,  250, 1,  0},
    '{7'd0,   200, 0,  35},
    '{7'd85,  200, 40, 20},
    '{7'd127, 300, 1,  0}
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  pfdw_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  pfdw_out_t out_data_o;
  logic      cfg_we_i    = 1'b0;
  logic [ROW_W-1:0] cfg_data_i = '0;

  // Scoreboard copy of the pixel store
  logic [COLOR_W-1:0] last_color [PIX_COUNT];
  bit                 needs_push [PIX_COUNT];
  logic [ROW_W-1:0]   cur_row_offset;
  pfdw_out_t          pending_writes [$];

  int unsigned idle_pct    = 20;
  int unsigned n_sent      = 0;
  int unsigned n_redraws   = 0;
  int unsigned n_unchanged = 0;
  int unsigned n_written   = 0;
  int unsigned n_cfg       = 0;
  int unsigned n_errors    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left  = 0;

  panel_frame_diff_writer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned pix_index(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    return int'(row) * VIEW_COLS + int'(col);
  endfunction

  // Apply one word to the scoreboard store; hit is set when a panel write follows
  function automatic void update_shown(input pfdw_in_t w, output bit hit,
                                       output pfdw_out_t wr);
    int unsigned      idx;
    logic [ROW_W-1:0] px;
    hit = 1'b0;
    wr  = '0;
    if (w.req_type == REQ_REDRAW) begin
      for (int i = 0; i < PIX_COUNT; i++) needs_push[i] = 1'b1;
      n_redraws++;
      return;
    end
    if (int'(w.pixel_col) >= VIEW_COLS || int'(w.pixel_row) >= VIEW_ROWS) return;
    idx = pix_index(w.pixel_col, w.pixel_row);
    if (!needs_push[idx] && last_color[idx] == w.pixel_color) begin
      n_unchanged++;
      return;
    end
    last_color[idx] = w.pixel_color;
    needs_push[idx] = 1'b0;
    px = w.pixel_row + cur_row_offset;
    wr.panel_addr = PANEL_ADDR_W'((VIEW_COLS - 1 - int'(w.pixel_col)) * PANEL_LINE + int'(px));
    wr.panel_data = w.pixel_color;
    hit = 1'b1;
  endfunction

  function automatic void report_miss(input string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endfunction

  // Random word: mostly hot spots near the corners, some reusing the shown color
  function automatic pfdw_in_t pick_pixel(input int unsigned redraw_pct);
    pfdw_in_t w;
    bit       hot;
    w.req_type    = ($urandom_range(0, 99) < redraw_pct) ? REQ_REDRAW : REQ_PIXEL;
    hot           = ($urandom_range(0, 99) < 65);
    w.pixel_color = COLOR_W'($urandom_range(0, 7));
    if (hot) begin
      w.pixel_col = COL_W'($urandom_range(0, 3));
      if ($urandom_range(0, 1) != 0) w.pixel_col = COL_W'(VIEW_COLS - 1) - w.pixel_col;
      w.pixel_row = ROW_W'($urandom_range(0, 3));
      if ($urandom_range(0, 1) != 0) w.pixel_row = ROW_W'(VIEW_ROWS - 1) - w.pixel_row;
      if ($urandom_range(0, 1) != 0)
        w.pixel_color = last_color[pix_index(w.pixel_col, w.pixel_row)];
    end else begin
      w.pixel_col = COL_W'($urandom_range(0, VIEW_COLS - 1));
      w.pixel_row = ROW_W'($urandom_range(0, VIEW_ROWS - 1));
    end
    return w;
  endfunction

  // A pixel that is sure to give a panel write, so its arrival marks the drain
  function automatic pfdw_in_t pick_changing();
    pfdw_in_t    w;
    int unsigned idx;
    w.req_type  = REQ_PIXEL;
    w.pixel_col = COL_W'($urandom_range(0, VIEW_COLS - 1));
    w.pixel_row = ROW_W'($urandom_range(0, VIEW_ROWS - 1));
    idx         = pix_index(w.pixel_col, w.pixel_row);
    if (needs_push[idx]) w.pixel_color = COLOR_W'($urandom_range(0, 7));
    else w.pixel_color = last_color[idx] ^ COLOR_W'($urandom_range(1, 7));
    return w;
  endfunction

  // Present one word, wait for it to be taken, then record what it should cause
  task automatic send_word(input pfdw_in_t w, input chk_e chk, input pfdw_out_t typed);
    bit        hit;
    pfdw_out_t wr;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
    update_shown(w, hit, wr);
    if (chk == CHK_BY_MODEL && hit) pending_writes.push_back(wr);
    else if (chk == CHK_TYPED) pending_writes.push_back(typed);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // Wait for every write to come out, plus the pipeline depth
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_row_offset(input logic [ROW_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    cur_row_offset = value;
    n_cfg++;
  endtask

  // Receiver: random stall bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 6);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each panel write with the oldest expectation
  always @(posedge clk_i) begin
    pfdw_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_written++;
      if (pending_writes.size() == 0) begin
        report_miss($sformatf("unexpected write addr=%0d data=%0d",
                              out_data_o.panel_addr, out_data_o.panel_data));
      end else begin
        want = pending_writes.pop_front();
        if (out_data_o.panel_addr != want.panel_addr)
          report_miss($sformatf("panel_addr expected %0d got %0d",
                                want.panel_addr, out_data_o.panel_addr));
        if (out_data_o.panel_data != want.panel_data)
          report_miss($sformatf("panel_data expected %0d got %0d (addr %0d)",
                                want.panel_data, out_data_o.panel_data, want.panel_addr));
      end
    end
  end

  // Watchdog: cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d quiet cycles, %0d writes pending",
                 quiet_cycles, pending_writes.size());
        $display("panel_frame_diff_writer_unit regression: fail");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    pfdw_out_t typed;
    for (int i = 0; i < PIX_COUNT; i++) begin
      last_color[i] = '0;
      needs_push[i] = 1'b1;
    end
    cur_row_offset = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table; block still sweeps its tags after reset
    foreach (DIR_TAB[i]) begin
      typed.panel_addr = DIR_TAB[i].addr;
      typed.panel_data = DIR_TAB[i].data;
      send_word('{req_type: DIR_TAB[i].req, pixel_col: DIR_TAB[i].col,
                  pixel_row: DIR_TAB[i].row, pixel_color: DIR_TAB[i].color},
                DIR_TAB[i].chk, typed);
    end
    send_word(pick_changing(), CHK_BY_MODEL, '0);
    drain();

    // random phases, each under its own row_offset
    foreach (PHASES[p]) begin
      idle_pct = PHASES[p].idle_pct;
      write_row_offset(PHASES[p].offset);
      for (int n = 0; n < PHASES[p].count; n++)
        send_word(pick_pixel(PHASES[p].redraw_pct), CHK_BY_MODEL, '0);
      send_word(pick_changing(), CHK_BY_MODEL, '0);
      drain();
    end

    if (pending_writes.size() != 0) begin
      n_errors += pending_writes.size();
      $display("%0d expected writes never arrived", pending_writes.size());
    end
    $display("covered %0d words (%0d redraws, %0d unchanged pixels), %0d panel writes",
             n_sent, n_redraws, n_unchanged, n_written);
    $display("across %0d row_offset settings, %0d mismatches", n_cfg, n_errors);
    if (n_errors == 0) begin
      $display("panel_frame_diff_writer_unit regression: pass");
    end else begin
      $display("panel_frame_diff_writer_unit regression: fail");
    end
    $finish;
  end

endmodule
